>>> hw/rtl/ntc_pkg.sv
// Package for the numeric type converter: type codes, stage records, helpers.
`default_nettype none
package ntc_pkg;

  localparam logic [3:0] TY_I8  = 4'd0;
  localparam logic [3:0] TY_U8  = 4'd1;
  localparam logic [3:0] TY_I16 = 4'd2;
  localparam logic [3:0] TY_U16 = 4'd3;
  localparam logic [3:0] TY_I32 = 4'd4;
  localparam logic [3:0] TY_U32 = 4'd5;
  localparam logic [3:0] TY_I64 = 4'd6;
  localparam logic [3:0] TY_U64 = 4'd7;
  localparam logic [3:0] TY_F32 = 4'd8;
  localparam logic [3:0] TY_F64 = 4'd9;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_NAN = 2'd2;

  localparam logic [7:0] REG_SOURCE = 8'd0;
  localparam logic [7:0] REG_DEST   = 8'd1;

  // after decode
  typedef struct packed {
    logic               sign;
    logic [63:0]        sig;
    logic signed [12:0] e;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
    logic [63:0]        raw;
    logic               last;
  } s1_t;

  // after normalize
  typedef struct packed {
    logic               sign;
    logic [63:0]        norm;
    logic signed [12:0] big_e;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
    logic [63:0]        raw;
    logic               last;
  } s2_t;

  // after align shift
  typedef struct packed {
    logic               sign;
    logic [63:0]        q;
    logic               rnd;
    logic               sticky;
    logic               subn;
    logic signed [12:0] big_e;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
    logic [63:0]        raw;
    logic               last;
  } s3_t;

  function automatic logic [6:0] type_width(input logic [3:0] t);
    logic [6:0] w;
    case (t)
      TY_I8, TY_U8:   w = 7'd8;
      TY_I16, TY_U16: w = 7'd16;
      TY_I32, TY_U32, TY_F32: w = 7'd32;
      default:        w = 7'd64;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] low_mask(input logic [6:0] w);
    logic [63:0] m;
    if (w >= 7'd64) m = '1;
    else m = (64'd1 << w[5:0]) - 64'd1;
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ntc_lzc.sv
// Leading zero count of a 64-bit word, two-level priority search.
`default_nettype none
module ntc_lzc (
  input  wire logic [63:0] din,
  output logic      [6:0]  count
);
  logic [7:0] grp_nz;
  logic [2:0] grp_lz [8];

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |din[g*8 +: 8];
      grp_lz[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (din[g*8 + b]) grp_lz[g] = 3'(7 - b);
      end
    end
  end

  always_comb begin
    count = 7'd64;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) count = {1'b0, 3'(7 - g), grp_lz[g]};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/numeric_type_converter_unit.sv
// Top level of the numeric type converter: four-stage conversion pipeline.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = value_in, s_tlast = last_in
//  m_*     | out | m_tvalid/m_tready  | m_tdata = value_out, conv_status; m_tlast
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index selects register, cfg_data value
//
// One word per cycle sustained while m_tready stays high. Four register stages
// (decode, normalize, align shift, round/saturate into output reg): an accepted
// word passes s1, s2, s3 and the output register before m_tvalid rises. Every
// stage has its own valid bit and advances when the stage after it is empty or
// moving, so bubbles collapse and the input keeps flowing while a result waits, as
// long as a stage is free. Synchronous reset clears valid bits and both type registers.
`default_nettype none
module numeric_type_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] value_in
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [71:0] m_tdata,   // [63:0] value_out, [65:64] conv_status, zero above
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  logic [3:0] source_type, dest_type;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_type <= ntc_pkg::TY_I8;
      dest_type   <= ntc_pkg::TY_I8;
    end else if (cfg_valid) begin
      if (cfg_index == ntc_pkg::REG_SOURCE) source_type <= cfg_data;
      else if (cfg_index == ntc_pkg::REG_DEST) dest_type <= cfg_data;
    end
  end

  // handshake chain
  logic v1, v2, v3;
  logic en1, en2, en3, en_o;
  assign en_o     = !m_tvalid || m_tready;
  assign en3      = !v3 || en_o;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  wire logic dst_float = (dest_type == ntc_pkg::TY_F32) || (dest_type == ntc_pkg::TY_F64);
  wire logic dst_f32   = (dest_type == ntc_pkg::TY_F32);

  // ---------------- stage 1: decode ----------------
  ntc_pkg::s1_t s1, s1_next;

  always_comb begin
    logic [6:0]  sw;
    logic [63:0] vext;
    logic [10:0] efield;
    logic [51:0] frac;
    logic        ef_zero, ef_full;
    s1_next      = '0;
    s1_next.last = s_tlast;
    sw           = ntc_pkg::type_width(source_type);
    vext         = s_tdata & ntc_pkg::low_mask(sw);
    efield       = '0;
    frac         = '0;
    ef_zero      = 1'b0;
    ef_full      = 1'b0;
    if (source_type == ntc_pkg::TY_F32) begin
      efield         = {3'd0, s_tdata[30:23]};
      frac           = {29'd0, s_tdata[22:0]};
      ef_zero        = (s_tdata[30:23] == 8'd0);
      ef_full        = (s_tdata[30:23] == 8'hff);
      s1_next.sign   = s_tdata[31];
      s1_next.raw    = vext;
      s1_next.sig    = {40'd0, !ef_zero, s_tdata[22:0]};
      s1_next.e      = (ef_zero ? 13'sd1 : $signed({2'b00, efield})) - 13'sd150;
    end else if (source_type == ntc_pkg::TY_F64) begin
      efield         = s_tdata[62:52];
      frac           = s_tdata[51:0];
      ef_zero        = (efield == 11'd0);
      ef_full        = (efield == 11'h7ff);
      s1_next.sign   = s_tdata[63];
      s1_next.raw    = vext;
      s1_next.sig    = {11'd0, !ef_zero, frac};
      s1_next.e      = (ef_zero ? 13'sd1 : $signed({2'b00, efield})) - 13'sd1075;
    end else begin
      if (!source_type[0] && vext[sw[5:0] - 6'd1]) begin
        s1_next.sign = 1'b1;
        vext         = vext | ~ntc_pkg::low_mask(sw);
      end
      s1_next.raw     = vext;
      s1_next.sig     = s1_next.sign ? (64'd0 - vext) : vext;
      s1_next.e       = 13'sd0;
      s1_next.is_zero = (vext == 64'd0);
    end
    if (source_type == ntc_pkg::TY_F32 || source_type == ntc_pkg::TY_F64) begin
      s1_next.is_nan  = ef_full && (frac != 52'd0);
      s1_next.is_inf  = ef_full && (frac == 52'd0);
      s1_next.is_zero = ef_zero && (frac == 52'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en1) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) s1 <= s1_next;
  end

  // ---------------- stage 2: normalize ----------------
  ntc_pkg::s2_t s2, s2_next;
  logic [6:0] lz;

  ntc_lzc u_lzc (.din(s1.sig), .count(lz));

  always_comb begin
    s2_next         = '0;
    s2_next.sign    = s1.sign;
    s2_next.norm    = s1.sig << lz[5:0];
    s2_next.big_e   = s1.e + 13'sd63 - $signed({6'd0, lz});
    s2_next.is_nan  = s1.is_nan;
    s2_next.is_inf  = s1.is_inf;
    s2_next.is_zero = s1.is_zero || lz[6];
    s2_next.raw     = s1.raw;
    s2_next.last    = s1.last;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en2) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en2 && v1) s2 <= s2_next;
  end

  // ---------------- stage 3: align shift ----------------
  ntc_pkg::s3_t s3, s3_next;

  always_comb begin
    logic signed [12:0] rs;
    logic signed [12:0] emin;
    logic signed [12:0] base;
    logic [6:0]         rs7;
    logic [127:0]       shifted;
    logic               subn;
    emin = dst_f32 ? -13'sd126 : -13'sd1022;
    base = dst_f32 ? 13'sd40 : 13'sd11;
    subn = 1'b0;
    if (dst_float) begin
      if (s2.big_e < emin) begin
        subn = 1'b1;
        rs   = base + (emin - s2.big_e);
      end else begin
        rs = base;
      end
    end else if (s2.big_e < 13'sd0 || s2.big_e > 13'sd63) begin
      rs = 13'sd64;
    end else begin
      rs = 13'sd63 - s2.big_e;
    end
    rs7     = (rs > 13'sd64) ? 7'd64 : rs[6:0];
    shifted = {s2.norm, 64'd0} >> rs7;
    s3_next         = '0;
    s3_next.sign    = s2.sign;
    s3_next.q       = shifted[127:64];
    if (rs > 13'sd64) begin
      s3_next.rnd    = 1'b0;
      s3_next.sticky = |s2.norm;
    end else begin
      s3_next.rnd    = shifted[63];
      s3_next.sticky = |shifted[62:0];
    end
    s3_next.subn    = subn;
    s3_next.big_e   = s2.big_e;
    s3_next.is_nan  = s2.is_nan;
    s3_next.is_inf  = s2.is_inf;
    s3_next.is_zero = s2.is_zero;
    s3_next.raw     = s2.raw;
    s3_next.last    = s2.last;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en3) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en3 && v2) s3 <= s3_next;
  end

  // ---------------- stage 4: round, pack, saturate ----------------
  logic [63:0] res_next;
  logic [1:0]  status_next;

  always_comb begin
    logic [5:0]         fb;
    logic [5:0]         tb;
    logic [63:0]        exp_full;
    logic [63:0]        qr;
    logic [11:0]        ef;
    logic [63:0]        sum;
    logic [63:0]        bits;
    logic [63:0]        top;
    logic [63:0]        pay;
    logic [6:0]         w;
    logic               sgn_dst;
    logic [63:0]        maxv, minv, mag;
    logic               too_big;
    fb       = dst_f32 ? 6'd23 : 6'd52;
    tb       = dst_f32 ? 6'd31 : 6'd63;
    exp_full = dst_f32 ? 64'hff : 64'h7ff;
    qr       = s3.q + {63'd0, s3.rnd && (s3.sticky || s3.q[0])};
    ef       = 12'(s3.big_e + (dst_f32 ? 13'sd126 : 13'sd1022));
    sum      = ({52'd0, ef} << fb) + qr;
    top      = {63'd0, s3.sign} << tb;
    pay      = dst_f32 ? {41'd0, s3.raw[51:29]} : {12'd0, s3.raw[22:0], 29'd0};
    w        = ntc_pkg::type_width(dest_type);
    sgn_dst  = !dest_type[0];
    maxv     = sgn_dst ? ntc_pkg::low_mask(w - 7'd1) : ntc_pkg::low_mask(w);
    minv     = sgn_dst ? (64'd1 << (w[5:0] - 6'd1)) : 64'd0;
    too_big  = s3.is_inf || (!s3.is_nan && !s3.is_zero && s3.big_e > 13'sd63);
    mag      = (s3.is_nan || s3.is_inf || s3.is_zero || s3.big_e < 13'sd0) ? 64'd0 : s3.q;
    bits     = '0;
    res_next    = '0;
    status_next = ntc_pkg::ST_OK;
    if (source_type > ntc_pkg::TY_F64 || dest_type > ntc_pkg::TY_F64) begin
      res_next = '0;
    end else if (source_type == dest_type) begin
      res_next = s3.raw & ntc_pkg::low_mask(ntc_pkg::type_width(source_type));
    end else if (source_type < ntc_pkg::TY_F32 && !dst_float) begin
      res_next = s3.raw & ntc_pkg::low_mask(w);
    end else if (dst_float) begin
      if (s3.is_nan) begin
        res_next = top | (exp_full << fb) | pay | (64'd1 << (fb - 6'd1));
      end else if (s3.is_inf) begin
        res_next = top | (exp_full << fb);
      end else if (s3.is_zero) begin
        res_next = top;
      end else begin
        if (s3.subn) begin
          bits = qr;
        end else if ((sum >> fb) >= exp_full) begin
          bits        = exp_full << fb;
          status_next = ntc_pkg::ST_SAT;
        end else begin
          bits = sum;
        end
        res_next = top | bits;
      end
    end else begin
      if (s3.is_nan) begin
        res_next    = '0;
        status_next = ntc_pkg::ST_NAN;
      end else if (too_big) begin
        res_next    = s3.sign ? minv : maxv;
        status_next = ntc_pkg::ST_SAT;
      end else if (s3.sign && mag != 64'd0) begin
        if (!sgn_dst || mag > minv) begin
          res_next    = minv;
          status_next = ntc_pkg::ST_SAT;
        end else begin
          res_next = (64'd0 - mag) & ntc_pkg::low_mask(w);
        end
      end else if (mag > maxv) begin
        res_next    = maxv;
        status_next = ntc_pkg::ST_SAT;
      end else begin
        res_next = mag;
      end
    end
  end

  logic [63:0] value_out;
  logic [1:0]  conv_status;
  logic        last_out;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en_o) m_tvalid <= v3;
  end
  always_ff @(posedge clk) begin
    if (en_o && v3) begin
      value_out   <= res_next;
      conv_status <= status_next;
      last_out    <= s3.last;
    end
  end

  assign m_tdata = {6'd0, conv_status, value_out};
  assign m_tlast = last_out;

  // ---------------- checks ----------------
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (conv_status == ntc_pkg::ST_OK || conv_status == ntc_pkg::ST_SAT ||
                  conv_status == ntc_pkg::ST_NAN))
    else $error("status code out of range");

  a_nan_int_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && conv_status == ntc_pkg::ST_NAN) |-> !dst_float)
    else $error("NaN status on float destination");

  a_byte_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (dest_type == ntc_pkg::TY_I8 || dest_type == ntc_pkg::TY_U8))
      |-> (value_out[63:8] == 56'd0))
    else $error("8-bit result has upper bits set");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for the numeric type converter: directed table, random streams, self-checking.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import ntc_pkg::*;

  localparam int IDLE_MAX     = 16;
  localparam int WATCHDOG_MAX = 4000;
  localparam int DRAIN_CYCLES = 12;  // pipeline is four deep, leave margin

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [3:0]  cfg_data;

  numeric_type_converter_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // one converted element as it should appear on the master side
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic        last;
  } conv_word_t;

  conv_word_t expected_words[$];

  logic [3:0] src_ty;
  logic [3:0] dst_ty;

  int mismatches;
  int words_sent;
  int words_checked;
  int idle_cycles;
  int settings_run;
  bit hold_off;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor helpers
  // ---------------------------------------------------------------------------
  function automatic int width_of(input logic [3:0] t);
    int w;
    case (t)
      TY_I8, TY_U8:           w = 8;
      TY_I16, TY_U16:         w = 16;
      TY_I32, TY_U32, TY_F32: w = 32;
      default:                w = 64;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] ones_below(input int w);
    logic [63:0] m;
    if (w >= 64) m = '1;
    else m = (64'd1 << w) - 64'd1;
    return m;
  endfunction

  function automatic int msb_pos(input logic [63:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = i;
    end
    return n;
  endfunction

  // round sig * 2^e to nearest even in a float format, flag overflow
  function automatic logic [63:0] round_to_float(input logic sgn, input logic [63:0] sig,
                                                 input int e, input int fbits,
                                                 input int ebits, inout logic [1:0] st);
    int          bias;
    int          emin;
    int          top_e;
    int          unit_e;
    int          sh;
    logic [63:0] efull;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] packed_bits;
    bias  = (1 << (ebits - 1)) - 1;
    emin  = 1 - bias;
    efull = (64'd1 << ebits) - 64'd1;
    top_e = msb_pos(sig) + e;
    unit_e = ((top_e < emin) ? emin : top_e) - fbits;
    sh = unit_e - e;
    if (sh <= 0) begin
      q = sig << (-sh);
    end else if (sh > 64) begin
      q = 0;
    end else begin
      q    = (sh == 64) ? 64'd0 : (sig >> sh);
      rem  = sig & ones_below(sh);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    if (top_e < emin) begin
      packed_bits = q;
    end else begin
      packed_bits = (64'(top_e + bias - 1) << fbits) + q;
      if ((packed_bits >> fbits) >= efull) begin
        packed_bits = efull << fbits;
        st = ST_SAT;
      end
    end
    return (64'(sgn) << (fbits + ebits)) | packed_bits;
  endfunction

  // expected conversion of one element under the current type setting
  function automatic conv_word_t convert_element(input logic [63:0] v, input logic lst);
    conv_word_t  r;
    logic [63:0] res;
    logic [1:0]  st;
    int          sw;
    int          w;
    logic [63:0] vext;
    logic        sgn;
    logic [63:0] mag;
    int          fb, eb, ofb, oeb, bias, e;
    logic [63:0] bits, efield, frac, efull, sig, maxv, minv;
    logic        is_nan, is_inf, is_zero, too_big, sgn_dst;
    res = 0;
    st  = ST_OK;
    if (src_ty > TY_F64 || dst_ty > TY_F64) begin
      res = 0;
    end else if (src_ty == dst_ty) begin
      res = v & ones_below(width_of(src_ty));
    end else if (src_ty < TY_F32) begin
      sw   = width_of(src_ty);
      vext = v & ones_below(sw);
      sgn  = 1'b0;
      if (!src_ty[0] && vext[sw-1]) begin
        sgn  = 1'b1;
        vext = vext | ~ones_below(sw);
      end
      if (dst_ty < TY_F32) begin
        res = vext & ones_below(width_of(dst_ty));
      end else begin
        mag = sgn ? (64'd0 - vext) : vext;
        if (mag == 0) res = 0;
        else if (dst_ty == TY_F32) res = round_to_float(sgn, mag, 0, 23, 8, st);
        else res = round_to_float(sgn, mag, 0, 52, 11, st);
      end
    end else begin
      fb     = (src_ty == TY_F32) ? 23 : 52;
      eb     = (src_ty == TY_F32) ? 8 : 11;
      bits   = v & ones_below(width_of(src_ty));
      sgn    = bits[fb+eb];
      efield = (bits >> fb) & ones_below(eb);
      frac   = bits & ones_below(fb);
      efull  = ones_below(eb);
      bias   = (1 << (eb - 1)) - 1;
      is_nan  = (efield == efull) && frac != 0;
      is_inf  = (efield == efull) && frac == 0;
      is_zero = (efield == 0) && frac == 0;
      sig = (efield == 0) ? frac : (frac | (64'd1 << fb));
      e   = ((efield == 0) ? 1 : int'(efield)) - bias - fb;
      if (dst_ty >= TY_F32) begin
        ofb = (dst_ty == TY_F32) ? 23 : 52;
        oeb = (dst_ty == TY_F32) ? 8 : 11;
        if (is_nan) begin
          res = (64'(sgn) << (ofb + oeb)) | (ones_below(oeb) << ofb)
              | ((ofb > fb) ? (frac << (ofb - fb)) : (frac >> (fb - ofb)))
              | (64'd1 << (ofb - 1));
        end else if (is_inf) begin
          res = (64'(sgn) << (ofb + oeb)) | (ones_below(oeb) << ofb);
        end else if (is_zero) begin
          res = 64'(sgn) << (ofb + oeb);
        end else begin
          res = round_to_float(sgn, sig, e, ofb, oeb, st);
        end
      end else begin
        w       = width_of(dst_ty);
        sgn_dst = !dst_ty[0];
        maxv    = sgn_dst ? ones_below(w - 1) : ones_below(w);
        minv    = sgn_dst ? (64'd1 << (w - 1)) : 64'd0;
        too_big = is_inf;
        mag     = 0;
        if (!is_nan && !is_inf && !is_zero) begin
          if (e >= 0) begin
            if (msb_pos(sig) + e >= 64) too_big = 1'b1;
            else mag = sig << e;
          end else if (e > -64) begin
            mag = sig >> (-e);
          end
        end
        if (is_nan) begin
          res = 0;
          st  = ST_NAN;
        end else if (too_big) begin
          res = sgn ? minv : maxv;
          st  = ST_SAT;
        end else if (sgn && mag != 0) begin
          if (!sgn_dst || mag > minv) begin
            res = minv;
            st  = ST_SAT;
          end else begin
            res = (64'd0 - mag) & ones_below(w);
          end
        end else if (mag > maxv) begin
          res = maxv;
          st  = ST_SAT;
        end else begin
          res = mag;
        end
      end
    end
    r.value  = res;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------
  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_type_reg(input logic [7:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SOURCE) src_ty = val;
    else if (idx == REG_DEST) dst_ty = val;
  endtask

  // wait for every outstanding word, then let the pipeline settle
  task automatic drain_pipeline();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_types(input logic [3:0] s, input logic [3:0] d);
    drain_pipeline();
    write_type_reg(REG_SOURCE, s);
    write_type_reg(REG_DEST, d);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // offer one word; prediction queued at the accepting edge
  task automatic send_word(input logic [63:0] v, input logic lst, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(convert_element(v, lst));
    words_sent++;
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
  endtask

  // random operand biased toward interesting shapes for the source type
  function automatic logic [63:0] pick_value(input logic [3:0] t);
    logic [63:0] v;
    int          k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (t == TY_F32) begin
      case (k)
        0: v[30:23] = 8'hff;
        1: v[30:23] = 8'h00;
        2: v[30:23] = 8'(127 + $urandom_range(0, 70));
        3: v[30:0]  = {8'hff, 23'd0};
        4: v[30:23] = 8'(100 + $urandom_range(0, 30));
        default: ;
      endcase
    end else if (t == TY_F64) begin
      case (k)
        0: v[62:52] = 11'h7ff;
        1: v[62:52] = 11'h000;
        2: v[62:52] = 11'(1023 + $urandom_range(0, 70));
        3: v[62:52] = 11'(1023 - 150 + $urandom_range(0, 300));
        4: v[62:52] = 11'(1023 - 127 - $urandom_range(0, 30));
        5: v[62:0]  = {11'h7ff, 52'd0};
        default: ;
      endcase
    end else begin
      case (k)
        0: v = 0;
        1: v = '1;
        2: v = 64'd1 << $urandom_range(0, 63);
        3: v = v >> $urandom_range(0, 63);
        default: ;
      endcase
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: types, operand, expected where obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [3:0]  s;
    logic [3:0]  d;
    logic [63:0] v;
    logic        lst;
    bit          known;
    logic [63:0] value;
    logic [1:0]  status;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    // after reset: i8 to i8 passes through, masked to eight bits
    '{TY_I8,  TY_I8,  64'hffff_ffff_ffff_ff80, 1'b0, 1'b1, 64'h80, ST_OK},
    '{TY_I8,  TY_I16, 64'h80, 1'b1, 1'b1, 64'hff80, ST_OK},
    '{TY_U8,  TY_I64, 64'hff, 1'b0, 1'b1, 64'hff, ST_OK},
    '{TY_I64, TY_I8,  64'h1234_5678_9abc_def0, 1'b0, 1'b1, 64'hf0, ST_OK},
    '{TY_U64, TY_F32, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 64'h5f80_0000, ST_OK},
    '{TY_I64, TY_F64, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'hc3e0_0000_0000_0000, ST_OK},
    '{TY_I32, TY_F32, 64'h0100_0001, 1'b0, 1'b0, 0, ST_OK},
    '{TY_F32, TY_I32, 64'h7fc0_0000, 1'b0, 1'b1, 0, ST_NAN},
    '{TY_F32, TY_I32, 64'h7f80_0000, 1'b0, 1'b1, 64'h7fff_ffff, ST_SAT},
    '{TY_F32, TY_I32, 64'hff80_0000, 1'b0, 1'b1, 64'h8000_0000, ST_SAT},
    '{TY_F32, TY_U8,  64'hbf80_0000, 1'b0, 1'b1, 0, ST_SAT},
    '{TY_F32, TY_U8,  64'hbf00_0000, 1'b0, 1'b1, 0, ST_OK},
    '{TY_F32, TY_I8,  64'hc300_0000, 1'b0, 1'b1, 64'h80, ST_OK},
    '{TY_F32, TY_I8,  64'hc301_0000, 1'b1, 1'b1, 64'h80, ST_SAT},
    '{TY_F64, TY_U64, 64'h7ff0_0000_0000_0000, 1'b0, 1'b1, '1, ST_SAT},
    '{TY_F64, TY_I64, 64'hc3e0_0000_0000_0000, 1'b0, 1'b1, 64'h8000_0000_0000_0000, ST_OK},
    '{TY_F64, TY_F32, 64'h7fef_ffff_ffff_ffff, 1'b0, 1'b1, 64'h7f80_0000, ST_SAT},
    '{TY_F64, TY_F32, 64'h0000_0000_0000_0001, 1'b0, 1'b1, 0, ST_OK},
    '{TY_F64, TY_F32, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'h8000_0000, ST_OK},
    '{TY_F64, TY_F32, 64'h3690_0000_0000_0001, 1'b0, 1'b0, 0, ST_OK},
    '{TY_F64, TY_F32, 64'hfff0_0000_0000_0001, 1'b0, 1'b0, 0, ST_OK},
    '{TY_F32, TY_F64, 64'h7f80_0001, 1'b0, 1'b0, 0, ST_OK},
    '{TY_F32, TY_F64, 64'h0000_0001, 1'b0, 1'b0, 0, ST_OK},
    '{4'd15,  TY_I32, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 0, ST_OK},
    '{TY_F32, 4'd10,  64'h3f80_0000, 1'b1, 1'b1, 0, ST_OK}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0] s;
    logic [3:0] d;
    int         n;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    src_ty    = TY_I8;
    dst_ty    = TY_I8;
    hold_off  = 1'b0;
    stim_done = 1'b0;
    mismatches = 0;
    words_sent = 0;
    settings_run = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first row runs on the reset setting, no write
    foreach (directed_rows[i]) begin
      if (i != 0) set_types(directed_rows[i].s, directed_rows[i].d);
      send_word(directed_rows[i].v, directed_rows[i].lst, 1'b0);
      end_burst();
      if (directed_rows[i].known) begin
        expected_words[$].value  = directed_rows[i].value;
        expected_words[$].status = directed_rows[i].status;
      end
    end

    // random bursts; each burst picks a type pair, mostly legal codes
    while (words_sent < 1900) begin
      s = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      d = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      set_types(s, d);
      n = $urandom_range(10, 60);
      // one burst with back-to-back words against a stalled receiver
      if (settings_run == 40) begin
        hold_off = 1'b1;
        n = 40;
      end
      for (int k = 0; k < n; k++) begin
        send_word(pick_value(s), 1'($urandom_range(0, 1)),
                  !hold_off && ($urandom_range(0, 3) != 0));
      end
      end_burst();
    end
    stim_done = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    conv_word_t want;
    if (rst) begin
      words_checked <= 0;
      idle_cycles   <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
          || !(m_tvalid || expected_words.size() != 0 || !stim_done))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        words_checked <= words_checked + 1;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", m_tdata);
        end else begin
          want = expected_words.pop_front();
          if (m_tdata[63:0] !== want.value || m_tdata[65:64] !== want.status
              || m_tdata[71:66] !== '0 || m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %h status %0d last %b, got value %h status %0d last %b",
                       want.value, want.status, want.last,
                       m_tdata[63:0], m_tdata[65:64], m_tlast);
          end
        end
      end
    end
  end

  // end of run
  initial begin
    @(negedge rst);
    wait (stim_done);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d words converted and checked across %0d type settings,", words_checked,
             settings_run);
    $display("including saturation, NaN, rounding, wrap and a long output stall.");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_lzc.sv
hw/rtl/numeric_type_converter_unit.sv
test/testbench.sv
